// File: rtl/ped_pkg.sv
// Shared types and constants for the palette error-diffusion dither.
package ped_pkg;

	localparam int CFG_W   = 9;   // palette_size register
	localparam int IDX_W   = 8;   // entry_index / color_index
	localparam int CH_W    = 8;   // one colour channel
	localparam int COLO_W  = 12;  // column result field
	localparam int ERR_W   = 16;  // stored error per channel
	localparam int CORR_W  = 10;  // corrected channel, signed
	localparam int CTB_W   = 18;  // one weighted error share, signed
	localparam int SQ_W    = 18;  // squared channel distance
	localparam int DIST_W  = 20;  // summed distance
	localparam int IN_W    = 32;
	localparam int OUT_W   = 24;

	typedef enum logic [1:0] {
		MODE_LOAD   = 2'd0,
		MODE_PIXEL  = 2'd1,
		MODE_START  = 2'd2,
		MODE_UNUSED = 2'd3   // no action, no result
	} mode_t;

	// neighbour updates, in the order they are applied
	typedef enum logic [1:0] {
		TGT_LL = 2'd0,   // next row, x-1, 3/16
		TGT_DN = 2'd1,   // next row, x,   5/16
		TGT_LR = 2'd2,   // next row, x+1, 1/16
		TGT_RT = 2'd3    // this row, x+1, 7/16
	} tgt_t;

	typedef struct packed {
		logic idle;       // input may be taken
		logic corr_load;  // register corrected pixel, start search
		logic err_load;   // work out the weighted error shares
		logic tgt_rd;     // read neighbour error word
		logic tgt_wr;     // write updated neighbour error word
		tgt_t tgt;
		logic finish;     // load result, advance column/row
	} ped_cmd_t;

	typedef struct packed {
		logic pix_go;      // pixel transaction accepted
		logic search_done; // nearest entry known
		logic tgt_skip;    // neighbour lies outside the row
		logic out_busy;    // result register still held
	} ped_sts_t;

endpackage

// File: rtl/ped_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ped_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/ped_ctrl.sv
// Sequencer for one pixel: correct, search, diffuse, deliver.
module ped_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  ped_pkg::ped_sts_t sts,
	output ped_pkg::ped_cmd_t cmd
);
	import ped_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_CORR, S_SEARCH, S_ERR, S_RD, S_WR, S_DONE
	} state_t;

	state_t state_q;
	tgt_t   tgt_q;

	always_comb begin
		cmd           = '0;
		cmd.tgt       = tgt_q;
		cmd.idle      = (state_q == S_IDLE);
		cmd.corr_load = (state_q == S_CORR);
		cmd.err_load  = (state_q == S_ERR);
		cmd.tgt_rd    = (state_q == S_RD);
		cmd.tgt_wr    = (state_q == S_WR);
		cmd.finish    = (state_q == S_DONE) && !sts.out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tgt_q   <= TGT_LL;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (sts.pix_go) begin
						state_q <= S_CORR;
					end
				end
				S_CORR: state_q <= S_SEARCH;
				S_SEARCH: begin
					if (sts.search_done) begin
						state_q <= S_ERR;
					end
				end
				S_ERR: begin
					tgt_q   <= TGT_LL;
					state_q <= S_RD;
				end
				S_RD: begin
					if (!sts.tgt_skip) begin
						state_q <= S_WR;
					end else if (tgt_q == TGT_RT) begin
						state_q <= S_DONE;
					end else begin
						tgt_q <= tgt_t'(tgt_q + 2'd1);
					end
				end
				S_WR: begin
					if (tgt_q == TGT_RT) begin
						state_q <= S_DONE;
					end else begin
						tgt_q   <= tgt_t'(tgt_q + 2'd1);
						state_q <= S_RD;
					end
				end
				S_DONE: begin
					if (!sts.out_busy) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/ped_dp.sv
// Datapath: palette and error stores, search pipeline, error arithmetic.
module ped_dp #(
	parameter int ROW_PIXELS      = 4096,
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ped_pkg::ped_cmd_t         cmd,
	output ped_pkg::ped_sts_t         sts,
	input  logic                      s_tvalid,
	input  logic [ped_pkg::IN_W-1:0]  s_tdata,
	input  logic [1:0]                s_tuser,
	input  logic                      s_tlast,
	input  logic                      cfg_we,
	input  logic [ped_pkg::CFG_W-1:0] cfg_wdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [ped_pkg::OUT_W-1:0] m_tdata,
	output logic                      m_tlast
);
	import ped_pkg::*;

	localparam int CW = $clog2(ROW_PIXELS);
	localparam int PW = $clog2(PALETTE_ENTRIES);
	localparam int AW = CW + 1;

	function automatic logic signed [7:0] div256(input logic signed [ERR_W-1:0] e);
		logic signed [ERR_W:0] t;
		t = (ERR_W+1)'(e) + ((e < 0) ? 17'sd255 : 17'sd0);
		return 8'(t >>> 8);
	endfunction

	function automatic logic signed [CTB_W-1:0] div16(input logic signed [20:0] v);
		logic signed [20:0] t;
		t = v + ((v < 0) ? 21'sd15 : 21'sd0);
		return CTB_W'(t >>> 4);
	endfunction

	// input decode
	logic            acc;
	logic [IDX_W-1:0] in_entry;
	logic [CH_W-1:0]  in_ch [3];
	assign acc       = s_tvalid & cmd.idle;
	assign in_entry  = s_tdata[7:0];
	assign in_ch[0]  = s_tdata[15:8];
	assign in_ch[1]  = s_tdata[23:16];
	assign in_ch[2]  = s_tdata[31:24];
	assign sts.pix_go = acc && (s_tuser == MODE_PIXEL);

	// configuration
	logic [CFG_W-1:0] psize_q;
	logic [PW-1:0]    nm1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psize_q <= CFG_W'(2);
		end else if (cfg_we) begin
			psize_q <= cfg_wdata;
		end
	end
	always_comb begin
		if (psize_q == '0) begin
			nm1 = '0;
		end else if (psize_q > CFG_W'(PALETTE_ENTRIES)) begin
			nm1 = PW'(PALETTE_ENTRIES - 1);
		end else begin
			nm1 = PW'(psize_q - CFG_W'(1));
		end
	end

	// palette store
	logic            pal_we;
	logic [PW-1:0]   iss_q;
	logic [3*CH_W-1:0] pal_rdata;
	assign pal_we = acc && (s_tuser == MODE_LOAD)
		&& ({1'b0, in_entry} < CFG_W'(PALETTE_ENTRIES));

	ped_ram #(.WIDTH(3*CH_W), .DEPTH(2**PW)) u_pal (
		.clk   (clk),
		.we    (pal_we),
		.waddr (in_entry[PW-1:0]),
		.wdata ({in_ch[2], in_ch[1], in_ch[0]}),
		.raddr (iss_q),
		.rdata (pal_rdata)
	);

	// row state
	logic          sel_q;
	logic [CW-1:0] col_q;
	logic [CW:0]   fill_q [2];
	logic [CW-1:0] x_q;
	logic          last_q;
	logic [CH_W-1:0] pix_q [3];

	// error store addressing
	logic          trow, rrow;
	logic [CW-1:0] tcol, rcol;
	logic          tgt_skip;
	logic          rv_q;
	logic          wrow_q;
	logic [CW-1:0] wcol_q;
	logic          err_we;
	logic [3*ERR_W-1:0] err_wdata, err_rdata;

	always_comb begin
		trow = (cmd.tgt == TGT_RT) ? sel_q : ~sel_q;
		case (cmd.tgt)
			TGT_LL:  tcol = x_q - CW'(1);
			TGT_DN:  tcol = x_q;
			default: tcol = x_q + CW'(1);
		endcase
		case (cmd.tgt)
			TGT_LL:  tgt_skip = (x_q == '0);
			TGT_DN:  tgt_skip = 1'b0;
			default: tgt_skip = last_q;
		endcase
		rrow = cmd.idle ? sel_q : trow;
		rcol = cmd.idle ? col_q : tcol;
	end
	assign sts.tgt_skip = tgt_skip;

	ped_ram #(.WIDTH(3*ERR_W), .DEPTH(2**AW)) u_err (
		.clk   (clk),
		.we    (err_we),
		.waddr ({wrow_q, wcol_q}),
		.wdata (err_wdata),
		.raddr ({rrow, rcol}),
		.rdata (err_rdata)
	);

	// pixel capture and read-valid tracking
	always_ff @(posedge clk) begin
		rv_q <= ({1'b0, rcol} < fill_q[rrow]);
		if (sts.pix_go) begin
			pix_q  <= in_ch;
			x_q    <= col_q;
			last_q <= s_tlast || (col_q == CW'(ROW_PIXELS - 1));
		end
		if (cmd.tgt_rd) begin
			wrow_q <= trow;
			wcol_q <= tcol;
		end
	end

	// corrected pixel
	logic signed [CORR_W-1:0] corr_q [3];
	always_ff @(posedge clk) begin
		if (cmd.corr_load) begin
			for (int i = 0; i < 3; i++) begin
				corr_q[i] <= signed'({2'b00, pix_q[i]})
					+ CORR_W'(div256(rv_q ? err_rdata[ERR_W*i +: ERR_W] : '0));
			end
		end
	end

	// nearest-entry search: issue, square, sum and compare
	logic              issuing_q, va_s1, lst_s1, va_s2, lst_s2, done_q;
	logic [PW-1:0]     idx_s1, idx_s2, best_q;
	logic [SQ_W-1:0]   sq_s2 [3];
	logic [3*CH_W-1:0] rgb_s2, brgb_q;
	logic [DIST_W-1:0] bd_q, dsum;
	logic signed [CORR_W-1:0] pdiff [3];
	logic signed [2*CORR_W-1:0] prod [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pdiff[i] = signed'({2'b00, pal_rdata[CH_W*i +: CH_W]}) - corr_q[i];
			prod[i]  = pdiff[i] * pdiff[i];
		end
		dsum = DIST_W'(sq_s2[0]) + DIST_W'(sq_s2[1]) + DIST_W'(sq_s2[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issuing_q <= 1'b0;
			va_s1     <= 1'b0;
			va_s2     <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			va_s1  <= issuing_q;
			va_s2  <= va_s1;
			done_q <= va_s2 && lst_s2;
			if (cmd.corr_load) begin
				issuing_q <= 1'b1;
			end else if (issuing_q && (iss_q == nm1)) begin
				issuing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.corr_load) begin
			iss_q <= '0;
		end else if (issuing_q) begin
			iss_q <= iss_q + PW'(1);
		end
		idx_s1 <= iss_q;
		lst_s1 <= (iss_q == nm1);
		idx_s2 <= idx_s1;
		lst_s2 <= lst_s1;
		rgb_s2 <= pal_rdata;
		for (int i = 0; i < 3; i++) begin
			sq_s2[i] <= SQ_W'(prod[i]);
		end
		if (va_s2 && ((idx_s2 == '0) || (dsum < bd_q))) begin
			bd_q   <= dsum;
			best_q <= idx_s2;
			brgb_q <= rgb_s2;
		end
	end
	assign sts.search_done = done_q;

	// weighted error shares, [target][channel]
	logic signed [CTB_W-1:0] ctb_q [4][3];
	logic signed [CORR_W-1:0] ediff [3];
	logic signed [CTB_W-1:0]  e255 [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ediff[i] = corr_q[i] - signed'({2'b00, brgb_q[CH_W*i +: CH_W]});
			e255[i]  = CTB_W'(ediff[i]) * 18'sd255;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.err_load) begin
			for (int i = 0; i < 3; i++) begin
				ctb_q[TGT_LL][i] <= div16(21'(e255[i]) * 21'sd3);
				ctb_q[TGT_DN][i] <= div16(21'(e255[i]) * 21'sd5);
				ctb_q[TGT_LR][i] <= div16(21'(e255[i]));
				ctb_q[TGT_RT][i] <= div16(21'(e255[i]) * 21'sd7);
			end
		end
	end

	// saturating read-modify-write
	logic signed [ERR_W-1:0] old_e [3];
	logic signed [CTB_W:0]   sum_e [3];
	always_comb begin
		err_we = cmd.tgt_wr;
		for (int i = 0; i < 3; i++) begin
			old_e[i] = rv_q ? signed'(err_rdata[ERR_W*i +: ERR_W]) : '0;
			sum_e[i] = (CTB_W+1)'(old_e[i]) + (CTB_W+1)'(ctb_q[cmd.tgt][i]);
			if (sum_e[i] > 19'sd32767) begin
				err_wdata[ERR_W*i +: ERR_W] = 16'h7FFF;
			end else if (sum_e[i] < -19'sd32768) begin
				err_wdata[ERR_W*i +: ERR_W] = 16'h8000;
			end else begin
				err_wdata[ERR_W*i +: ERR_W] = ERR_W'(sum_e[i]);
			end
		end
	end

	// row bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q     <= 1'b0;
			col_q     <= '0;
			fill_q[0] <= '0;
			fill_q[1] <= '0;
		end else begin
			if (acc && (s_tuser == MODE_START)) begin
				sel_q     <= 1'b0;
				col_q     <= '0;
				fill_q[0] <= '0;
				fill_q[1] <= '0;
			end
			if (cmd.tgt_wr && ({1'b0, wcol_q} >= fill_q[wrow_q])) begin
				fill_q[wrow_q] <= {1'b0, wcol_q} + (CW+1)'(1);
			end
			if (cmd.finish) begin
				if (last_q) begin
					fill_q[sel_q] <= '0;
					sel_q         <= ~sel_q;
					col_q         <= '0;
				end else begin
					col_q <= x_q + CW'(1);
				end
			end
		end
	end

	// result register
	logic             out_valid_q;
	logic [IDX_W-1:0] out_idx_q;
	logic [COLO_W-1:0] out_col_q;
	logic             out_last_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_idx_q  <= IDX_W'(best_q);
			out_col_q  <= COLO_W'(x_q);
			out_last_q <= last_q;
		end
	end
	assign sts.out_busy = out_valid_q & ~m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_col_q, out_idx_q};
	assign m_tlast  = out_last_q;

endmodule

// File: rtl/palette_error_diffusion_dither.sv
// Top level of the palette error-diffusion dither.
//
// Input stream (s_*): one transaction per item. s_tuser carries the kind:
//   load a palette entry, a pixel, or start of a new image. s_tlast marks
//   the last pixel of a row. Pixels arrive in raster order.
// Output stream (m_*): one transaction per pixel, carrying the chosen
//   palette index and the pixel's column; m_tlast ends a row.
// cfg_we/cfg_wdata write palette_size, the number of entries searched.
// Load and start transactions give no output.
// For a pixel, the nearest-colour search reads one palette entry per cycle
//   from the palette RAM, and four read-modify-writes of the error RAM
//   (fewer at row edges) spread the error.
// The result sits in an output register; a stalled receiver holds the next
//   pixel in its final step until that register is taken.
// Reset clears control state, both error rows (by fill counts, no sweep)
//   and sets palette_size to 2; the palette is undefined until loaded.
module palette_error_diffusion_dither #(
	parameter int ROW_PIXELS      = 4096,
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [ped_pkg::IN_W-1:0]  s_tdata,  // entry_index, red, green, blue
	input  logic [1:0]                s_tuser,  // mode
	input  logic                      s_tlast,  // row_end
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [ped_pkg::OUT_W-1:0] m_tdata,  // color_index, column, zero pad
	output logic                      m_tlast,  // row_last
	input  logic                      cfg_we,
	input  logic [ped_pkg::CFG_W-1:0] cfg_wdata // palette_size
);
	import ped_pkg::*;

	ped_cmd_t cmd;
	ped_sts_t sts;

	// input taken only between pixels
	assign s_tready = cmd.idle;

	ped_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	ped_dp #(
		.ROW_PIXELS      (ROW_PIXELS),
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tvalid  (s_tvalid),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

// File: test/testbench.sv
// Self-checking testbench for the palette error-diffusion dither.
`timescale 1ns / 100ps

module testbench;
	import ped_pkg::*;

	localparam int ROW        = 4096;
	localparam int PAL        = 256;
	localparam int SETTLE     = 320;       // beyond the longest pixel
	localparam int LIMIT      = 4_000_000; // cycle budget for the whole run

	// ports
	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata;   // entry_index, red, green, blue
	logic [1:0]        s_tuser;   // mode
	logic              s_tlast;   // row_end
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;   // color_index, column, zero pad
	logic              m_tlast;   // row_last
	logic              cfg_we;
	logic [CFG_W-1:0]  cfg_wdata; // palette_size

	palette_error_diffusion_dither dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// one expected output transaction
	typedef struct {
		logic [7:0]  color;
		logic [11:0] col;
		logic        last;
	} dither_out_t;

	dither_out_t expected_pixels[$];

	// shadow copy of the block's state
	logic [23:0] pal_rgb [PAL];      // {blue, green, red}
	shortint     err_rows [2][ROW][3];
	bit          row_sel;
	int          col_next;
	int          pal_size;

	int          fails;
	int          cycles;
	int          gap_pct;            // chance per cycle the sender idles
	int          stall_pct;          // chance per cycle the receiver stalls
	int          hold_left;          // long receiver hold-off, counted down below

	// clock, 4 ns period
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// cycle budget; a hang ends the run here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Receiver: random stalls, or a long hold-off while hold_left runs down.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Output checker. Sampled on the falling edge: a transaction happens at the
	// next rising edge exactly when valid and ready are both high here.
	always @(negedge clk) begin
		dither_out_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_pixels.size() == 0) begin
				$display("%0t: unexpected result: index %0d column %0d last %0b", $realtime,
					m_tdata[7:0], m_tdata[19:8], m_tlast);
				fails++;
			end else begin
				want = expected_pixels.pop_front();
				if (m_tdata[7:0] !== want.color) begin
					$display("%0t: color_index expected %0d actual %0d", $realtime,
						want.color, m_tdata[7:0]);
					fails++;
				end
				if (m_tdata[19:8] !== want.col) begin
					$display("%0t: column expected %0d actual %0d", $realtime,
						want.col, m_tdata[19:8]);
					fails++;
				end
				if (m_tlast !== want.last) begin
					$display("%0t: row_last expected %0b actual %0b", $realtime,
						want.last, m_tlast);
					fails++;
				end
				if (m_tdata[23:20] !== 4'd0) begin
					$display("%0t: pad bits expected 0 actual %0h", $realtime, m_tdata[23:20]);
					fails++;
				end
			end
		end
	end

	// saturating update of one stored error
	function automatic shortint sat_add(shortint cur, int amount);
		int sum;
		sum = int'(cur) + amount;
		if (sum > 32767)  sum = 32767;
		if (sum < -32768) sum = -32768;
		return shortint'(sum);
	endfunction

	task automatic clear_errors();
		for (int r = 0; r < 2; r++)
			for (int x = 0; x < ROW; x++)
				for (int c = 0; c < 3; c++)
					err_rows[r][x][c] = 0;
	endtask

	// Dither one pixel against the shadow state and queue its result.
	task automatic dither_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue,
			logic row_end);
		int          x, cur, nxt, count, best, best_d, d, diff, e3;
		int          corr [3];
		int          chan [3];
		bit          last;
		dither_out_t res;
		x    = (col_next >= ROW) ? ROW - 1 : col_next;
		cur  = row_sel;
		nxt  = cur ^ 1;
		last = row_end || (x == ROW - 1);
		chan[0] = red; chan[1] = green; chan[2] = blue;
		for (int c = 0; c < 3; c++)
			corr[c] = chan[c] + int'(err_rows[cur][x][c]) / 256;
		// 0 searches one entry, anything above the table searches all of it
		count = (pal_size == 0) ? 1 : (pal_size > PAL ? PAL : pal_size);
		best   = 0;
		best_d = 0;
		for (int e = 0; e < count; e++) begin
			d = 0;
			for (int c = 0; c < 3; c++) begin
				diff = int'(pal_rgb[e][c*8 +: 8]) - corr[c];
				d += diff * diff;
			end
			if (e == 0 || d < best_d) begin
				best_d = d;
				best   = e;
			end
		end
		for (int c = 0; c < 3; c++) begin
			e3 = 255 * (corr[c] - int'(pal_rgb[best][c*8 +: 8]));
			if (!last) begin
				err_rows[cur][x+1][c] = sat_add(err_rows[cur][x+1][c], e3 * 7 / 16);
				err_rows[nxt][x+1][c] = sat_add(err_rows[nxt][x+1][c], e3 * 1 / 16);
			end
			if (x > 0)
				err_rows[nxt][x-1][c] = sat_add(err_rows[nxt][x-1][c], e3 * 3 / 16);
			err_rows[nxt][x][c] = sat_add(err_rows[nxt][x][c], e3 * 5 / 16);
		end
		res.color = best[7:0];
		res.col   = x[11:0];
		res.last  = last;
		expected_pixels.push_back(res);
		if (last) begin
			for (int xx = 0; xx < ROW; xx++)
				for (int c = 0; c < 3; c++)
					err_rows[cur][xx][c] = 0;
			row_sel  = ~row_sel;
			col_next = 0;
		end else begin
			col_next = x + 1;
		end
	endtask

	// Offer one item; returns once its transaction has happened, then updates
	// the shadow state. Ready is looked at on the falling edge so the test
	// never races the block's own updates. Valid stays up for the next item;
	// an idle gap before that item or drain() drops it.
	task automatic send_item(logic [1:0] mode, logic [7:0] entry, logic [7:0] red,
			logic [7:0] green, logic [7:0] blue, logic row_end);
		bit taken;
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {blue, green, red, entry};
		s_tlast  <= row_end;
		taken = 0;
		while (!taken) begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end
		case (mode)
			MODE_LOAD:  pal_rgb[entry] = {blue, green, red};
			MODE_START: begin
				clear_errors();
				row_sel  = 0;
				col_next = 0;
			end
			MODE_PIXEL: dither_pixel(red, green, blue, row_end);
			default: ;   // unused mode, ignored
		endcase
	endtask

	// Sender stops until every queued result is out, and the block is quiet.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_palette_size(int value);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= value[CFG_W-1:0];
		@(posedge clk);
		cfg_we    <= 1'b0;
		pal_size   = value & 9'h1FF;
	endtask

	task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic row_end);
		send_item(MODE_PIXEL, 8'($urandom), r, g, b, row_end);
	endtask

	// Extremes, every mode, saturation, palette size 0 and the reset size.
	task automatic test_directed();
		send_item(MODE_LOAD, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
		send_item(MODE_LOAD, 8'd1, 8'd255, 8'd255, 8'd255, 1'b1);
		send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		send_pixel(8'd128, 8'd127, 8'd128, 1'b0);
		send_pixel(8'd127, 8'd128, 8'd127, 1'b1);
		send_item(MODE_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
		send_pixel(8'd64, 8'd200, 8'd10, 1'b1);             // one-pixel row
		send_item(MODE_START, 8'hAA, 8'h55, 8'hAA, 8'h55, 1'b1);
		// single black entry: large errors pile up and saturate
		write_palette_size(0);
		for (int i = 0; i < 6; i++)
			send_pixel(8'd255, 8'd255, 8'd255, i == 5);
		for (int i = 0; i < 4; i++)
			send_pixel(8'd255, 8'd0, 8'd255, i == 3);
		write_palette_size(2);
		send_item(MODE_START, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
		send_pixel(8'd100, 8'd100, 8'd100, 1'b0);
		send_pixel(8'd200, 8'd30, 8'd90, 1'b1);
	endtask

	int pal_size_list[4] = '{256, 255, 300, 511};

	// Whole palette loaded, then the largest sizes and the clamp above it.
	task automatic test_full_palette();
		for (int e = 0; e < PAL; e++)
			send_item(MODE_LOAD, e[7:0], 8'($urandom), 8'($urandom), 8'($urandom),
				1'($urandom));
		foreach (pal_size_list[i]) begin
			write_palette_size(pal_size_list[i]);
			for (int p = 0; p < 5; p++)
				send_pixel(8'($urandom), 8'($urandom), 8'($urandom), p == 4);
		end
	endtask

	// Receiver holds off for long while the sender keeps offering pixels.
	task automatic test_backpressure();
		write_palette_size(16);
		hold_left = 400;
		for (int i = 0; i < 12; i++)
			send_pixel(8'($urandom), 8'($urandom), 8'($urandom), i % 5 == 4);
		drain();
	endtask

	// Short rows of random pixels, with loads, starts and noise among them.
	task automatic test_random(int items);
		int run_len, run_pos, pick;
		run_len = $urandom_range(12, 1);
		run_pos = 0;
		for (int i = 0; i < items; i++) begin
			pick = $urandom_range(99);
			if (pick < 80) begin
				run_pos++;
				send_pixel(8'($urandom), 8'($urandom), 8'($urandom), run_pos == run_len);
				if (run_pos == run_len) begin
					run_pos = 0;
					run_len = ($urandom_range(9) == 0) ? $urandom_range(60, 13)
						: $urandom_range(12, 1);
				end
			end else if (pick < 88) begin
				send_item(MODE_LOAD, 8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom), 1'($urandom));
			end else if (pick < 94) begin
				send_item(MODE_START, 8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom), 1'($urandom));
				run_pos = 0;
			end else begin
				send_item(MODE_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom), 1'($urandom));
			end
		end
	endtask

	// Random part run under each idling pattern and a spread of palette sizes.
	task automatic test_idle_phases();
		int gaps[4]   = '{0, 71, 0, 23};
		int stalls[4] = '{0, 0, 71, 23};
		for (int ph = 0; ph < 4; ph++) begin
			gap_pct   = gaps[ph];
			stall_pct = stalls[ph];
			write_palette_size($urandom_range(20, 1));
			test_random(110);
			write_palette_size($urandom_range(256, 1));
			test_random(40);
		end
		gap_pct   = 0;
		stall_pct = 0;
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = MODE_LOAD;
		s_tlast   = 1'b0;
		m_tready  = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		fails     = 0;
		cycles    = 0;
		gap_pct   = 0;
		stall_pct = 0;
		hold_left = 0;
		for (int e = 0; e < PAL; e++)
			pal_rgb[e] = '0;
		clear_errors();
		row_sel  = 0;
		col_next = 0;
		pal_size = 2;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_palette();
		test_backpressure();
		test_idle_phases();

		drain();
		if (fails == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
